FILE: hdl/qrmi_pkg.sv
// shared types and constants for the quad region mean intensity block
package qrmi_pkg;

   localparam int CORNERS         = 4;
   localparam int VALUE_WIDTH     = 8;
   localparam int SUM_WIDTH       = 32;
   localparam int OUT_COUNT_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DIV_STEPS       = SUM_WIDTH;
   localparam int STEP_WIDTH      = $clog2(DIV_STEPS);

   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(DIV_STEPS - 1);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_X0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_Y0 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_X1 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_Y1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_X2 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_Y2 = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_X3 = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_Y3 = 3'd7;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DRAIN,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic acc_last;
   } ctrl_stat_type;

endpackage

FILE: hdl/quad_region_mean_intensity_top.sv
// top level of the quad region mean intensity block
//
//   channel  direction  handshake                 word
//   req      in         req_valid / req_ready     pixel_x, pixel_y, pixel_value, last_pixel
//   rsp      out        rsp_valid / rsp_ready     mean_value, inside_count, used_fallback
//   csr      in         csr_write_en              csr_index, csr_data
//
// one pixel word per cycle while req_ready is high; a taken word passes the registered
//   inside-test pipeline before the accumulators; after a last_pixel word req_ready stays
//   low for pipeline drain, divider load, 32 steps of the bit-serial divider, result load
// a result still waiting on rsp_ready holds off the next result load, and req_ready with it
// synchronous active-high reset clears corners, accumulators and all valid flags
module quad_region_mean_intensity_top #(
   parameter int COORD_WIDTH = 12,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [COORD_WIDTH-1:0]               req_pixel_x,
   input  logic [COORD_WIDTH-1:0]               req_pixel_y,
   input  logic [qrmi_pkg::VALUE_WIDTH-1:0]     req_pixel_value,
   input  logic                                 req_last_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [qrmi_pkg::VALUE_WIDTH-1:0]     rsp_mean_value,
   output logic [qrmi_pkg::OUT_COUNT_WIDTH-1:0] rsp_inside_count,
   output logic                                 rsp_used_fallback,
   input  logic                                 csr_write_en,
   input  logic [qrmi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_data
);
   import qrmi_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   qrmi_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .stat           (stat)
   );

   qrmi_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_value   (req_pixel_value),
      .req_last_pixel    (req_last_pixel),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_inside_count  (rsp_inside_count),
      .rsp_used_fallback (rsp_used_fallback)
   );

endmodule

FILE: hdl/qrmi_ctrl.sv
// controller state machine: input flow, divide sequencing and result handshake
module qrmi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_last_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output qrmi_pkg::ctrl_cmd_type  cmd,
   input  qrmi_pkg::ctrl_stat_type stat
);
   import qrmi_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_RUN);
      case (state_ff)
         ST_RUN: begin
            cmd.take = req_valid;
            if (req_valid && req_last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.acc_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_last_only_drain: assert property (@(posedge clock) disable iff (reset)
      stat.acc_last |-> state_ff == ST_DRAIN)
      else $error("last word reached accumulator outside drain");

   a_drain_to_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && stat.acc_last |=> state_ff == ST_LOAD)
      else $error("divide not started after last word");

   a_full_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && step_ff == STEP_LAST |=> state_ff == ST_FINISH)
      else $error("divide did not end after all steps");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");
`endif

endmodule

FILE: hdl/qrmi_datapath.sv
// datapath: corner registers, inside-test pipeline, accumulators, serial divider
module qrmi_datapath #(
   parameter int COORD_WIDTH = 12,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qrmi_pkg::ctrl_cmd_type               cmd,
   output qrmi_pkg::ctrl_stat_type              stat,
   input  logic                                 csr_write_en,
   input  logic [qrmi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_data,
   input  logic [COORD_WIDTH-1:0]               req_pixel_x,
   input  logic [COORD_WIDTH-1:0]               req_pixel_y,
   input  logic [qrmi_pkg::VALUE_WIDTH-1:0]     req_pixel_value,
   input  logic                                 req_last_pixel,
   output logic [qrmi_pkg::VALUE_WIDTH-1:0]     rsp_mean_value,
   output logic [qrmi_pkg::OUT_COUNT_WIDTH-1:0] rsp_inside_count,
   output logic                                 rsp_used_fallback
);
   import qrmi_pkg::*;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;

   // corner registers
   logic [COORD_WIDTH-1:0] corner_x_ff [CORNERS];
   logic [COORD_WIDTH-1:0] corner_y_ff [CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORNERS; k++) begin
            corner_x_ff[k] <= '0;
            corner_y_ff[k] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CORNER_X0: corner_x_ff[0] <= csr_data;
            CSR_CORNER_Y0: corner_y_ff[0] <= csr_data;
            CSR_CORNER_X1: corner_x_ff[1] <= csr_data;
            CSR_CORNER_Y1: corner_y_ff[1] <= csr_data;
            CSR_CORNER_X2: corner_x_ff[2] <= csr_data;
            CSR_CORNER_Y2: corner_y_ff[2] <= csr_data;
            CSR_CORNER_X3: corner_x_ff[3] <= csr_data;
            CSR_CORNER_Y3: corner_y_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: accepted word
   logic                   s1_valid_ff, s1_last_ff;
   logic [COORD_WIDTH-1:0] s1_x_ff, s1_y_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.take;
      end
      if (cmd.take) begin
         s1_x_ff     <= req_pixel_x;
         s1_y_ff     <= req_pixel_y;
         s1_value_ff <= req_pixel_value;
         s1_last_ff  <= req_last_pixel;
      end
   end

   // stage 2: per-edge gates and differences
   logic [COORD_WIDTH-1:0]   min_x, min_y;
   logic                     corner_hit, fb_hit;
   logic [CORNERS-1:0]       gate_c, vert_c, dxpos_c;
   logic signed [DIFF_W-1:0] dx_c  [CORNERS];
   logic signed [DIFF_W-1:0] dy_c  [CORNERS];
   logic signed [DIFF_W-1:0] dpx_c [CORNERS];
   logic signed [DIFF_W-1:0] dpy_c [CORNERS];

   always_comb begin
      min_x = corner_x_ff[0];
      min_y = corner_y_ff[0];
      for (int k = 1; k < CORNERS; k++) begin
         if (corner_x_ff[k] < min_x) min_x = corner_x_ff[k];
         if (corner_y_ff[k] < min_y) min_y = corner_y_ff[k];
      end
      fb_hit     = (s1_x_ff == min_x) && (s1_y_ff == min_y);
      corner_hit = 1'b0;
      for (int k = 0; k < CORNERS; k++) begin
         if (corner_x_ff[k] == s1_x_ff && corner_y_ff[k] == s1_y_ff) begin
            corner_hit = 1'b1;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CORNERS; k++) begin
         automatic logic [COORD_WIDTH-1:0] xa = corner_x_ff[k];
         automatic logic [COORD_WIDTH-1:0] ya = corner_y_ff[k];
         automatic logic [COORD_WIDTH-1:0] xb = corner_x_ff[(k + 1) % CORNERS];
         automatic logic [COORD_WIDTH-1:0] yb = corner_y_ff[(k + 1) % CORNERS];
         automatic logic [COORD_WIDTH-1:0] lo = (xa < xb) ? xa : xb;
         automatic logic [COORD_WIDTH-1:0] hi = (xa < xb) ? xb : xa;
         gate_c[k]  = (s1_x_ff >= lo) && (s1_x_ff <= hi)
                      && ((s1_y_ff <= ya) || (s1_y_ff <= yb));
         vert_c[k]  = (xa == xb);
         dxpos_c[k] = (xb > xa);
         dx_c[k]    = $signed({1'b0, xb}) - $signed({1'b0, xa});
         dy_c[k]    = $signed({1'b0, yb}) - $signed({1'b0, ya});
         dpx_c[k]   = $signed({1'b0, s1_x_ff}) - $signed({1'b0, xa});
         dpy_c[k]   = $signed({1'b0, s1_y_ff}) - $signed({1'b0, ya});
      end
   end

   logic                     s2_valid_ff, s2_last_ff, s2_corner_ff, s2_fb_ff;
   logic [VALUE_WIDTH-1:0]   s2_value_ff;
   logic [CORNERS-1:0]       s2_gate_ff, s2_vert_ff, s2_dxpos_ff;
   logic signed [DIFF_W-1:0] s2_dx_ff  [CORNERS];
   logic signed [DIFF_W-1:0] s2_dy_ff  [CORNERS];
   logic signed [DIFF_W-1:0] s2_dpx_ff [CORNERS];
   logic signed [DIFF_W-1:0] s2_dpy_ff [CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff   <= s1_last_ff;
      s2_value_ff  <= s1_value_ff;
      s2_corner_ff <= corner_hit;
      s2_fb_ff     <= fb_hit;
      s2_gate_ff   <= gate_c;
      s2_vert_ff   <= vert_c;
      s2_dxpos_ff  <= dxpos_c;
      for (int k = 0; k < CORNERS; k++) begin
         s2_dx_ff[k]  <= dx_c[k];
         s2_dy_ff[k]  <= dy_c[k];
         s2_dpx_ff[k] <= dpx_c[k];
         s2_dpy_ff[k] <= dpy_c[k];
      end
   end

   // stage 3: cross products, one pair per edge
   logic                     s3_valid_ff, s3_last_ff, s3_corner_ff, s3_fb_ff;
   logic [VALUE_WIDTH-1:0]   s3_value_ff;
   logic [CORNERS-1:0]       s3_gate_ff, s3_vert_ff, s3_dxpos_ff;
   logic signed [PROD_W-1:0] s3_lhs_ff [CORNERS];
   logic signed [PROD_W-1:0] s3_rhs_ff [CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_last_ff   <= s2_last_ff;
      s3_value_ff  <= s2_value_ff;
      s3_corner_ff <= s2_corner_ff;
      s3_fb_ff     <= s2_fb_ff;
      s3_gate_ff   <= s2_gate_ff;
      s3_vert_ff   <= s2_vert_ff;
      s3_dxpos_ff  <= s2_dxpos_ff;
      for (int k = 0; k < CORNERS; k++) begin
         s3_lhs_ff[k] <= s2_dpy_ff[k] * s2_dx_ff[k];
         s3_rhs_ff[k] <= s2_dy_ff[k] * s2_dpx_ff[k];
      end
   end

   // stage 4: edge crossings and parity
   logic [CORNERS-1:0] hit_c;

   always_comb begin
      for (int k = 0; k < CORNERS; k++) begin
         hit_c[k] = s3_gate_ff[k]
                    && (s3_vert_ff[k]
                        || (s3_dxpos_ff[k] ? (s3_lhs_ff[k] <= s3_rhs_ff[k])
                                           : (s3_lhs_ff[k] >= s3_rhs_ff[k])));
      end
   end

   logic                   s4_valid_ff, s4_last_ff, s4_inside_ff, s4_fb_ff;
   logic [VALUE_WIDTH-1:0] s4_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_last_ff   <= s3_last_ff;
      s4_value_ff  <= s3_value_ff;
      s4_fb_ff     <= s3_fb_ff;
      s4_inside_ff <= s3_corner_ff || (^hit_c);
   end

   assign stat.acc_last = s4_valid_ff && s4_last_ff;

   // accumulators
   logic [SUM_WIDTH-1:0]   sum_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [VALUE_WIDTH-1:0] fallback_ff;
   logic [SUM_WIDTH:0]     sum_ext;

   assign sum_ext = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(s4_value_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         fallback_ff <= '0;
      end else if (s4_valid_ff) begin
         if (s4_fb_ff) begin
            fallback_ff <= s4_value_ff;
         end
         if (s4_inside_ff) begin
            if (count_ff != '1) begin
               count_ff <= count_ff + COUNT_WIDTH'(1);
            end
            sum_ff <= sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
         end
      end
   end

   // restoring divider, one quotient bit per step
   logic [COUNT_WIDTH-1:0] rem_ff;
   logic [SUM_WIDTH-1:0]   quo_ff;
   logic [COUNT_WIDTH:0]   rem_sh, rem_sub;
   logic                   fits;

   assign rem_sh  = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign fits    = (rem_sh >= {1'b0, count_ff});
   assign rem_sub = rem_sh - {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= sum_ff;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
         quo_ff <= {quo_ff[SUM_WIDTH-2:0], fits};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (count_ff == '0) begin
            rsp_mean_value    <= fallback_ff;
            rsp_inside_count  <= '0;
            rsp_used_fallback <= 1'b1;
         end else begin
            rsp_mean_value    <= (|quo_ff[SUM_WIDTH-1:VALUE_WIDTH]) ? '1
                                                                    : quo_ff[VALUE_WIDTH-1:0];
            rsp_inside_count  <= OUT_COUNT_WIDTH'(count_ff);
            rsp_used_fallback <= 1'b0;
         end
      end
   end

endmodule

FILE: dv/quad_region_mean_intensity_top_tb.sv
// self-checking testbench for the quad region mean intensity block
`timescale 1ns / 100ps

module quad_region_mean_intensity_top_tb;

   localparam int ITEM_TARGET  = 1100;
   localparam int DRAIN_CYCLES = 48;
   localparam int IDLE_LIMIT   = 4000;
   localparam int COORD_MAX    = 4095;

   localparam logic [qrmi_pkg::CSR_INDEX_WIDTH-1:0] X_REGS [4] = '{
      qrmi_pkg::CSR_CORNER_X0, qrmi_pkg::CSR_CORNER_X1,
      qrmi_pkg::CSR_CORNER_X2, qrmi_pkg::CSR_CORNER_X3};
   localparam logic [qrmi_pkg::CSR_INDEX_WIDTH-1:0] Y_REGS [4] = '{
      qrmi_pkg::CSR_CORNER_Y0, qrmi_pkg::CSR_CORNER_Y1,
      qrmi_pkg::CSR_CORNER_Y2, qrmi_pkg::CSR_CORNER_Y3};

   typedef struct packed {
      logic [7:0]  mean_value;
      logic [23:0] inside_count;
      logic        used_fallback;
   } region_result_type;

   class region_scoreboard_type;
      logic [11:0]       vert_x [4];
      logic [11:0]       vert_y [4];
      logic [31:0]       value_total;
      logic [23:0]       hit_count;
      logic [7:0]        anchor_value;
      region_result_type expected_q [$];
      int                mismatches;

      function new();
         for (int k = 0; k < 4; k++) begin
            vert_x[k] = '0;
            vert_y[k] = '0;
         end
         value_total  = '0;
         hit_count    = '0;
         anchor_value = '0;
         mismatches   = 0;
      endfunction

      function void set_corner(int k, logic [11:0] x, logic [11:0] y);
         vert_x[k] = x;
         vert_y[k] = y;
      endfunction

      // exact crossing test of edge a -> b, no division
      function bit edge_hit(longint px, longint py, int a, int b);
         longint xa, ya, xb, yb, lo, hi, dx, dy;
         xa = vert_x[a];
         ya = vert_y[a];
         xb = vert_x[b];
         yb = vert_y[b];
         lo = (xa < xb) ? xa : xb;
         hi = (xa < xb) ? xb : xa;
         if (px < lo || px > hi) return 1'b0;
         if (!(py <= ya || py <= yb)) return 1'b0;
         dx = xb - xa;
         dy = yb - ya;
         if (dx == 0) return px == xa;
         if (dx > 0) return (py - ya) * dx <= dy * (px - xa);
         return (py - ya) * dx >= dy * (px - xa);
      endfunction

      function bit covers(logic [11:0] x, logic [11:0] y);
         int crossings;
         crossings = 0;
         for (int k = 0; k < 4; k++)
            if (vert_x[k] == x && vert_y[k] == y) return 1'b1;
         for (int k = 0; k < 4; k++)
            if (edge_hit(longint'(x), longint'(y), k, (k + 1) % 4)) crossings++;
         return crossings[0];
      endfunction

      function void note_pixel(logic [11:0] x, logic [11:0] y, logic [7:0] v, logic last);
         logic [11:0]       min_x, min_y;
         logic [31:0]       quotient;
         region_result_type want;
         min_x = vert_x[0];
         min_y = vert_y[0];
         for (int k = 1; k < 4; k++) begin
            if (vert_x[k] < min_x) min_x = vert_x[k];
            if (vert_y[k] < min_y) min_y = vert_y[k];
         end
         if (x == min_x && y == min_y) anchor_value = v;
         if (covers(x, y)) begin
            if (hit_count != '1) hit_count++;
            value_total = (value_total > 32'hFFFF_FFFF - 32'(v)) ? 32'hFFFF_FFFF
                                                                 : value_total + 32'(v);
         end
         if (!last) return;
         if (hit_count != 0) begin
            quotient           = value_total / 32'(hit_count);
            want.mean_value    = (quotient > 32'd255) ? 8'hFF : quotient[7:0];
            want.inside_count  = hit_count;
            want.used_fallback = 1'b0;
         end else begin
            want.mean_value    = anchor_value;
            want.inside_count  = '0;
            want.used_fallback = 1'b1;
         end
         expected_q.push_back(want);
         value_total  = '0;
         hit_count    = '0;
         anchor_value = '0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [7:0] mean, logic [23:0] count, logic fallback);
         region_result_type want;
         if (expected_q.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         want = expected_q.pop_front();
         if (mean !== want.mean_value)
            report($sformatf("mean_value %0d, expected %0d", mean, want.mean_value));
         if (count !== want.inside_count)
            report($sformatf("inside_count %0d, expected %0d", count, want.inside_count));
         if (fallback !== want.used_fallback)
            report($sformatf("used_fallback %0b, expected %0b", fallback,
                             want.used_fallback));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_pixel_x = '0;
   logic [11:0] req_pixel_y = '0;
   logic [7:0]  req_pixel_value = '0;
   logic        req_last_pixel = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_mean_value;
   logic [23:0] rsp_inside_count;
   logic        rsp_used_fallback;
   logic        csr_write_en = 1'b0;
   logic [qrmi_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [11:0] csr_data = '0;

   region_scoreboard_type sb;
   int gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold = 0;
   int sent_count = 0;
   int idle_cycles = 0;
   int quad_x [4];
   int quad_y [4];
   int box_x0, box_x1, box_y0, box_y1;

   quad_region_mean_intensity_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_value   (req_pixel_value),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_inside_count  (rsp_inside_count),
      .rsp_used_fallback (rsp_used_fallback),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [11:0] clamp_coord(int v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return 12'(COORD_MAX);
      return 12'(v);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_hold = pick_gap(rsp_stall_pct);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_mean_value, rsp_inside_count, rsp_used_fallback);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles with no word moving", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                             input logic [7:0] v, input logic last);
      int gap;
      gap = pick_gap(gap_pct);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      req_pixel_value <= v;
      req_last_pixel  <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(x, y, v, last);
      sent_count++;
   endtask

   // stop sending, wait out every result and the divider tail
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
      quad_x = '{x0, x1, x2, x3};
      quad_y = '{y0, y1, y2, y3};
      box_x0 = COORD_MAX;
      box_y0 = COORD_MAX;
      box_x1 = 0;
      box_y1 = 0;
      for (int k = 0; k < 4; k++) begin
         if (quad_x[k] < box_x0) box_x0 = quad_x[k];
         if (quad_x[k] > box_x1) box_x1 = quad_x[k];
         if (quad_y[k] < box_y0) box_y0 = quad_y[k];
         if (quad_y[k] > box_y1) box_y1 = quad_y[k];
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= X_REGS[k];
         csr_data     <= 12'(quad_x[k]);
         @(negedge clock);
         csr_index    <= Y_REGS[k];
         csr_data     <= 12'(quad_y[k]);
         sb.set_corner(k, 12'(quad_x[k]), 12'(quad_y[k]));
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one scan: mostly near the quad; corners, box origin, corner x/y pairs, random points
   task automatic random_scan(int len);
      int pick, k, j;
      logic [11:0] x, y;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, 3);
         j    = $urandom_range(0, 3);
         if (pick < 45) begin
            x = clamp_coord(box_x0 - 2 + int'($urandom_range(0, box_x1 - box_x0 + 4)));
            y = clamp_coord(box_y0 - 2 + int'($urandom_range(0, box_y1 - box_y0 + 4)));
         end else if (pick < 60) begin
            x = 12'(quad_x[k]);
            y = 12'(quad_y[k]);
         end else if (pick < 68) begin
            x = 12'(box_x0);
            y = 12'(box_y0);
         end else if (pick < 78) begin
            x = 12'(quad_x[k]);
            y = 12'(quad_y[j]);
         end else begin
            x = 12'($urandom_range(0, COORD_MAX));
            y = 12'($urandom_range(0, COORD_MAX));
         end
         send_pixel(x, y, 8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   initial begin
      int shape, cx, cy, rad, base, x0, y0, w, h, nscans;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners at reset: all at the origin
      send_pixel(12'd4095, 12'd4095, 8'd0, 1'b1);
      send_pixel(12'd0, 12'd0, 8'd255, 1'b1);
      drain();

      // axis-aligned square: interior, vertex, each edge, last on an edge
      set_quad(100, 100, 100, 300, 300, 300, 300, 100);
      send_pixel(12'd200, 12'd200, 8'd10, 1'b0);
      send_pixel(12'd100, 12'd100, 8'd20, 1'b0);
      send_pixel(12'd100, 12'd200, 8'd30, 1'b0);
      send_pixel(12'd300, 12'd200, 8'd40, 1'b0);
      send_pixel(12'd200, 12'd100, 8'd50, 1'b0);
      send_pixel(12'd200, 12'd300, 8'd60, 1'b1);
      // one pixel inside: the box origin, a vertex, seen again
      send_pixel(12'd50, 12'd50, 8'd0, 1'b0);
      send_pixel(12'd100, 12'd100, 8'd77, 1'b0);
      send_pixel(12'd101, 12'd99, 8'd88, 1'b1);
      // nothing inside, origin never seen
      send_pixel(12'd4095, 12'd0, 8'd255, 1'b1);
      drain();

      set_quad(0, 0, 0, 4095, 4095, 4095, 4095, 0);
      send_pixel(12'd2048, 12'd2048, 8'd128, 1'b0);
      send_pixel(12'd4095, 12'd4095, 8'd255, 1'b0);
      send_pixel(12'd0, 12'd4095, 8'd1, 1'b0);
      send_pixel(12'd4095, 12'd0, 8'd254, 1'b0);
      send_pixel(12'd0, 12'd0, 8'd0, 1'b0);
      send_pixel(12'd1, 12'd1, 8'd255, 1'b1);
      drain();

      // slanted quad, one pixel exactly on a sloped edge
      set_quad(1000, 500, 600, 3000, 3500, 3600, 3900, 200);
      send_pixel(12'd2000, 12'd2000, 8'd99, 1'b0);
      send_pixel(12'd800, 12'd1750, 8'd3, 1'b0);
      send_pixel(12'd1000, 12'd500, 8'd200, 1'b1);
      drain();

      while (sent_count < ITEM_TARGET) begin
         shape = $urandom_range(0, 9);
         case (shape)
            0: set_quad(0, 0, 0, 0, 0, 0, 0, 0);
            1: set_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
            2: set_quad(0, 0, 0, 4095, 4095, 4095, 4095, 0);
            3, 4: begin
               x0 = $urandom_range(0, 4000);
               y0 = $urandom_range(0, 4000);
               w  = $urandom_range(0, 60);
               h  = $urandom_range(0, 60);
               set_quad(x0, y0, x0, y0 + h, x0 + w, y0 + h, x0 + w, y0);
            end
            5, 6, 7: begin
               cx  = $urandom_range(200, 3895);
               cy  = $urandom_range(200, 3895);
               rad = $urandom_range(5, 150);
               set_quad(cx - int'($urandom_range(0, rad)), cy - int'($urandom_range(0, rad)),
                        cx - int'($urandom_range(0, rad)), cy + int'($urandom_range(0, rad)),
                        cx + int'($urandom_range(0, rad)), cy + int'($urandom_range(0, rad)),
                        cx + int'($urandom_range(0, rad)), cy - int'($urandom_range(0, rad)));
            end
            8: begin
               base = $urandom_range(0, 3800);
               set_quad(base + int'($urandom_range(0, 295)), base + int'($urandom_range(0, 295)),
                        base + int'($urandom_range(0, 295)), base + int'($urandom_range(0, 295)),
                        base + int'($urandom_range(0, 295)), base + int'($urandom_range(0, 295)),
                        base + int'($urandom_range(0, 295)), base + int'($urandom_range(0, 295)));
            end
            default: begin
               set_quad($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            gap_pct       = 0;
            rsp_stall_pct = 0;
         end else begin
            gap_pct       = $urandom_range(5, 50);
            rsp_stall_pct = $urandom_range(5, 60);
         end
         nscans = $urandom_range(2, 6);
         repeat (nscans) begin
            if ($urandom_range(0, 7) == 0) begin
               random_scan($urandom_range(40, 120));
            end else begin
               random_scan($urandom_range(1, 16));
            end
         end
         drain();
      end

      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
